// ===== hw/rtl/factorial_probe_hash_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the factorial probe hash table
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FACTORIAL_PROBE_HASH_TABLE_ASSERT_SVH
`define FACTORIAL_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define FPHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FPHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPHT_ASSERT(lbl, clk, rst, prop, msg)
`define FPHT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/fpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Factorial probe hash table package
// Sizes, codes and shared types of the hash table and its remainder unit.
// ----------------------------------------------------------------------------
package fpht_pkg;

   localparam int TABLE_DEPTH  = 4096;
   localparam int PROBE_LIMIT  = 100;
   localparam int KEY_WIDTH    = 64;

   localparam int ADDR_WIDTH   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int HASH_WIDTH   = 32;
   localparam int KEY_IN_WIDTH = 64;
   localparam int SIZE_WIDTH   = 13;
   localparam int SLOT_WIDTH   = 12;
   localparam int COLL_WIDTH   = 7;
   localparam int CNT_WIDTH    = $clog2(PROBE_LIMIT + 1);

   localparam int STEP_BITS      = 4;
   localparam int STEP_COUNT     = HASH_WIDTH / STEP_BITS;
   localparam int STEP_CNT_WIDTH = $clog2(STEP_COUNT);

   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(4096);

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_CHECK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [HASH_WIDTH-1:0] dividend;
      logic [SIZE_WIDTH-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                  done;
      logic [SIZE_WIDTH-1:0] remainder;
   } mod_rsp_type;

   typedef struct packed {
      logic [SLOT_WIDTH-1:0] slot;
      logic                  found;
      logic                  inserted;
      logic                  table_full;
      logic [COLL_WIDTH-1:0] collisions;
   } result_type;

endpackage

// ===== hw/rtl/fpht_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one lookup or insert request word.
// ----------------------------------------------------------------------------
interface fpht_req_if;
   import fpht_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [HASH_WIDTH-1:0]   hash_value;
   logic [KEY_IN_WIDTH-1:0] key;

   modport source (output valid, output opcode, output hash_value, output key, input ready);
   modport sink   (input valid, input opcode, input hash_value, input key, output ready);
endinterface

// ===== hw/rtl/fpht_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface fpht_rsp_if;
   import fpht_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SLOT_WIDTH-1:0] slot;
   logic                  found;
   logic                  inserted;
   logic                  table_full;
   logic [COLL_WIDTH-1:0] collisions;

   modport source (output valid, output slot, output found, output inserted,
                   output table_full, output collisions, input ready);
   modport sink   (input valid, input slot, input found, input inserted,
                   input table_full, input collisions, output ready);
endinterface

// ===== hw/rtl/fpht_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the table size register write word.
// ----------------------------------------------------------------------------
interface fpht_csr_if;
   import fpht_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SIZE_WIDTH-1:0] table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

// ===== hw/rtl/fpht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fpht_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of a 32-bit word by the table size, four bits a cycle.
// ----------------------------------------------------------------------------
module fpht_mod_unit (
   input  logic                clock,
   input  logic                reset,
   input  fpht_pkg::mod_req_type mod_req,
   output fpht_pkg::mod_rsp_type mod_rsp
);
   import fpht_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic [STEP_CNT_WIDTH-1:0] cnt_ff;
   logic [HASH_WIDTH-1:0]     dvd_ff;
   logic [HASH_WIDTH-1:0]     dvd_in;
   logic [SIZE_WIDTH-1:0]     rem_ff;
   logic [SIZE_WIDTH-1:0]     rem_in;
   logic [SIZE_WIDTH-1:0]     div_ff;

   always_comb begin
      logic [SIZE_WIDTH:0] trial;
      rem_in = rem_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {rem_in, dvd_ff[HASH_WIDTH-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in = trial[SIZE_WIDTH-1:0];
      end
      dvd_in = dvd_ff << STEP_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mod_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= mod_req.dividend;
            rem_ff  <= '0;
            div_ff  <= mod_req.divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_WIDTH'(STEP_COUNT - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

// ===== hw/rtl/factorial_probe_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Factorial probe hash table
// Open-addressed key table probed with factorial offsets under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
// A request word on req_bus brings an opcode (lookup or insert), a 32-bit hash
// and a key. One result word per request leaves on rsp_bus. The table size
// register is written through csr_bus; the user must write it only while
// the block is idle, as the block itself does not enforce this. Each probe
// reduces a 32-bit position by the table size in the remainder unit, then
// reads the key RAM and compares. The block takes one request at a time.
// After reset a clearing pass writes every slot of the key RAM as empty,
// one slot a cycle, and no request is taken until it ends. A finished
// result sits in an output register; while the receiver stalls the next
// request is still taken and worked on, and its result waits in the
// sequencer until the output register is free.
// ----------------------------------------------------------------------------
`include "factorial_probe_hash_table_assert.svh"

module factorial_probe_hash_table (
   input logic        clock,
   input logic        reset,
   fpht_req_if.sink   req_bus,
   fpht_rsp_if.source rsp_bus,
   fpht_csr_if.sink   csr_bus
);
   import fpht_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [SIZE_WIDTH-1:0] size_eff;
   logic [ADDR_WIDTH-1:0] clr_ff;
   logic [ADDR_WIDTH-1:0] clr_in;
   logic                  op_ff;
   logic                  op_in;
   logic [KEY_WIDTH-1:0]  key_ff;
   logic [KEY_WIDTH-1:0]  key_in;
   logic [SIZE_WIDTH-1:0] pos_ff;
   logic [SIZE_WIDTH-1:0] pos_in;
   logic [HASH_WIDTH-1:0] offset_ff;
   logic [HASH_WIDTH-1:0] offset_in;
   logic [HASH_WIDTH-1:0] offset_next;
   logic [HASH_WIDTH+CNT_WIDTH-1:0] product;
   logic [CNT_WIDTH-1:0]  mult_ff;
   logic [CNT_WIDTH-1:0]  mult_in;
   logic [CNT_WIDTH-1:0]  coll_ff;
   logic [CNT_WIDTH-1:0]  coll_in;
   result_type            res_ff;
   result_type            res_in;
   result_type            out_ff;
   logic                  out_valid_ff;
   logic                  load_out;
   logic                  entry_valid;
   logic                  key_match;

   mod_req_type           mod_req;
   mod_rsp_type           mod_rsp;

   logic                  wr_en;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [KEY_WIDTH:0]    wr_data;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [KEY_WIDTH:0]    rd_data;

   fpht_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   fpht_ram #(
      .WIDTH (KEY_WIDTH + 1),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_WIDTH'(1);
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         size_eff = SIZE_WIDTH'(TABLE_DEPTH);
      end else begin
         size_eff = size_ff;
      end
   end

   assign product     = (HASH_WIDTH+CNT_WIDTH)'(offset_ff - HASH_WIDTH'(1))
                      * (HASH_WIDTH+CNT_WIDTH)'(mult_ff);
   assign offset_next = product[HASH_WIDTH-1:0] + HASH_WIDTH'(1);
   assign entry_valid = rd_data[KEY_WIDTH];
   assign key_match   = (rd_data[KEY_WIDTH-1:0] == key_ff);

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      op_in            = op_ff;
      key_in           = key_ff;
      pos_in           = pos_ff;
      offset_in        = offset_ff;
      mult_in          = mult_ff;
      coll_in          = coll_ff;
      res_in           = res_ff;
      load_out         = 1'b0;
      req_bus.ready    = 1'b0;
      mod_req.start    = 1'b0;
      mod_req.dividend = HASH_WIDTH'(pos_ff) + offset_next;
      mod_req.divisor  = size_eff;
      wr_en            = 1'b0;
      wr_addr          = ADDR_WIDTH'(pos_ff);
      wr_data          = {1'b1, key_ff};
      rd_addr          = ADDR_WIDTH'(mod_rsp.remainder);
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_WIDTH'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in            = req_bus.opcode;
               key_in           = req_bus.key[KEY_WIDTH-1:0];
               offset_in        = HASH_WIDTH'(2);
               mult_in          = CNT_WIDTH'(1);
               coll_in          = '0;
               mod_req.start    = 1'b1;
               mod_req.dividend = req_bus.hash_value;
               state_in         = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_rsp.done) begin
               pos_in   = mod_rsp.remainder;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!entry_valid || key_match) begin
               res_in.slot       = SLOT_WIDTH'(pos_ff);
               res_in.found      = entry_valid;
               res_in.inserted   = !entry_valid && (op_ff == OP_INSERT);
               res_in.table_full = 1'b0;
               res_in.collisions = COLL_WIDTH'(coll_ff);
               wr_en             = !entry_valid && (op_ff == OP_INSERT);
               state_in          = S_FINISH;
            end else if (coll_ff == CNT_WIDTH'(PROBE_LIMIT - 1)) begin
               res_in.slot       = '0;
               res_in.found      = 1'b0;
               res_in.inserted   = 1'b0;
               res_in.table_full = 1'b1;
               res_in.collisions = COLL_WIDTH'(PROBE_LIMIT);
               state_in          = S_FINISH;
            end else begin
               coll_in       = coll_ff + 1'b1;
               offset_in     = offset_next;
               mult_in       = mult_ff + 1'b1;
               mod_req.start = 1'b1;
               state_in      = S_MOD;
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         size_ff      <= SIZE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_bus.valid) begin
            size_ff <= csr_bus.table_size;
         end
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      offset_ff <= offset_in;
      mult_ff   <= mult_in;
      coll_ff   <= coll_in;
      res_ff    <= res_in;
      if (load_out) begin
         out_ff <= res_ff;
      end
   end

   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.slot       = out_ff.slot;
   assign rsp_bus.found      = out_ff.found;
   assign rsp_bus.inserted   = out_ff.inserted;
   assign rsp_bus.table_full = out_ff.table_full;
   assign rsp_bus.collisions = out_ff.collisions;

   `FPHT_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> state_ff == S_CLEAR, "no clearing pass after reset")
   `FPHT_ASSERT(a_no_accept_in_clear, clock, reset, state_ff == S_CLEAR |-> !req_bus.ready, "request taken during clearing pass")
   `FPHT_ASSERT(a_rem_below_size, clock, reset, mod_rsp.done |-> mod_rsp.remainder < size_eff, "remainder not below table size")
   `FPHT_ASSERT(a_full_is_failure, clock, reset, rsp_bus.valid && rsp_bus.table_full |-> !rsp_bus.found && !rsp_bus.inserted && rsp_bus.slot == '0, "full result reports a slot")

endmodule

// ===== sim/tb_factorial_probe_hash_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the factorial probe hash table
// Drives lookup and insert words with random gaps while the result side
// stalls at random. Every accepted word is run through a local copy of the
// table, and each returned result is checked field by field. The table
// size register is rewritten between phases, including zero, one and
// oversized values, so that the collision path and the probe limit are hit.
// ----------------------------------------------------------------------------
module tb_factorial_probe_hash_table;
   import fpht_pkg::*;

   localparam int unsigned RUN_LIMIT_NS  = 60_000_000;
   localparam int unsigned SETTLE_CYCLES = 1100;
   localparam int unsigned MAX_REPORTS   = 10;

   typedef enum logic [1:0] {
      STIM_REQUEST,
      STIM_TABLE_SIZE,
      STIM_DRAIN
   } stim_kind_type;

   typedef struct packed {
      stim_kind_type           kind;
      logic                    opcode;
      logic [HASH_WIDTH-1:0]   hash_value;
      logic [KEY_IN_WIDTH-1:0] key;
      logic [SIZE_WIDTH-1:0]   table_size;
   } stim_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpht_req_if req_bus ();
   fpht_rsp_if rsp_bus ();
   fpht_csr_if csr_bus ();

   factorial_probe_hash_table u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   stim_word_type pending_q[$];
   result_type    expected_q[$];

   logic                 slot_used [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0] slot_tag  [TABLE_DEPTH];
   logic [SIZE_WIDTH-1:0] size_reg;

   int unsigned fail_count   = 0;
   int unsigned n_requests   = 0;
   int unsigned n_found      = 0;
   int unsigned n_inserted   = 0;
   int unsigned n_full       = 0;
   int unsigned n_size_writes = 0;
   int unsigned n_pauses     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Run did not finish within %0d ns.", RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned draw_idle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Walks the local copy of the table exactly as the block should, and
   // updates it when the word inserts.
   function automatic result_type probe_table(logic opcode,
                                              logic [HASH_WIDTH-1:0] hash_value,
                                              logic [KEY_IN_WIDTH-1:0] key_in);
      result_type           res;
      logic [31:0]          modulus;
      logic [31:0]          pos;
      logic [31:0]          offset;
      logic [31:0]          mult;
      logic [KEY_WIDTH-1:0] tag;
      int unsigned          idx;
      int                   n;
      if (size_reg == 0)
         modulus = 1;
      else if (size_reg > TABLE_DEPTH)
         modulus = TABLE_DEPTH;
      else
         modulus = 32'(size_reg);
      tag    = key_in[KEY_WIDTH-1:0];
      pos    = hash_value % modulus;
      offset = 2;
      mult   = 1;
      res    = '0;
      for (n = 0; n < PROBE_LIMIT; n++) begin
         pos = pos % modulus;
         idx = pos;
         if (!slot_used[idx] || slot_tag[idx] == tag) begin
            res.slot       = SLOT_WIDTH'(idx);
            res.found      = slot_used[idx];
            res.collisions = COLL_WIDTH'(n);
            if (!slot_used[idx] && opcode == OP_INSERT) begin
               slot_used[idx] = 1'b1;
               slot_tag[idx]  = tag;
               res.inserted   = 1'b1;
            end
            return res;
         end
         offset = (offset - 1) * mult + 1;
         mult   = mult + 1;
         pos    = pos + offset;
      end
      res.table_full = 1'b1;
      res.collisions = COLL_WIDTH'(PROBE_LIMIT);
      return res;
   endfunction

   task automatic flag_mismatch(string what, result_type want, result_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("[%0t] %s: expected slot=%0d found=%0d inserted=%0d full=%0d coll=%0d",
                  $time, what, want.slot, want.found, want.inserted, want.table_full,
                  want.collisions);
         $display("          got slot=%0d found=%0d inserted=%0d full=%0d coll=%0d",
                  got.slot, got.found, got.inserted, got.table_full, got.collisions);
      end
   endtask

   always @(posedge clock) begin : drive_requests
      stim_word_type word;
      result_type    want;
      logic          req_valid_nxt;
      logic          csr_valid_nxt;
      int unsigned   send_gap;
      int unsigned   quiet_send;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         send_gap   = 0;
         quiet_send = 0;
         size_reg   = SIZE_RESET;
         for (int i = 0; i < TABLE_DEPTH; i++)
            slot_used[i] = 1'b0;
      end else begin
         req_valid_nxt = req_bus.valid;
         csr_valid_nxt = csr_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            want = probe_table(req_bus.opcode, req_bus.hash_value, req_bus.key);
            expected_q.insert(expected_q.size(), want);
            n_requests++;
            n_found    += want.found;
            n_inserted += want.inserted;
            n_full     += want.table_full;
            req_valid_nxt = 1'b0;
            if (quiet_send > 0) begin
               quiet_send--;
               send_gap = 0;
            end else begin
               if ($urandom_range(0, 49) == 0)
                  quiet_send = $urandom_range(20, 60);
               send_gap = draw_idle();
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            size_reg = csr_bus.table_size;
            n_size_writes++;
            csr_valid_nxt = 1'b0;
         end
         if (!req_valid_nxt && !csr_valid_nxt) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_q.size() > 0) begin
               case (pending_q[0].kind)
                  STIM_REQUEST: begin
                     word = pending_q.pop_front();
                     req_valid_nxt = 1'b1;
                     req_bus.opcode     <= word.opcode;
                     req_bus.hash_value <= word.hash_value;
                     req_bus.key        <= word.key;
                  end
                  STIM_TABLE_SIZE: begin
                     word = pending_q.pop_front();
                     csr_valid_nxt = 1'b1;
                     csr_bus.table_size <= word.table_size;
                  end
                  default: begin
                     if (expected_q.size() == 0) begin
                        word = pending_q.pop_front();
                        n_pauses++;
                        send_gap = 2;
                     end
                  end
               endcase
            end
         end
         req_bus.valid <= req_valid_nxt;
         csr_bus.valid <= csr_valid_nxt;
      end
   end

   always @(posedge clock) begin : check_results
      result_type  want;
      result_type  got;
      logic        ready_nxt;
      int unsigned stall_left;
      int unsigned quiet_rsp;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         quiet_rsp  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.slot       = rsp_bus.slot;
            got.found      = rsp_bus.found;
            got.inserted   = rsp_bus.inserted;
            got.table_full = rsp_bus.table_full;
            got.collisions = rsp_bus.collisions;
            if (expected_q.size() == 0) begin
               flag_mismatch("result with nothing outstanding", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (got.slot !== want.slot || got.found !== want.found ||
                   got.inserted !== want.inserted || got.table_full !== want.table_full ||
                   got.collisions !== want.collisions)
                  flag_mismatch("result mismatch", want, got);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_nxt = 1'b0;
         end else if (quiet_rsp > 0) begin
            quiet_rsp--;
            ready_nxt = 1'b1;
         end else begin
            if ($urandom_range(0, 99) == 0)
               quiet_rsp = $urandom_range(100, 400);
            stall_left = ($urandom_range(0, 3) == 0) ? draw_idle() : 0;
            ready_nxt  = (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end
         rsp_bus.ready <= ready_nxt;
      end
   end

   task automatic push_request(logic opcode, logic [HASH_WIDTH-1:0] hash_value,
                               logic [KEY_IN_WIDTH-1:0] key);
      stim_word_type word;
      word            = '0;
      word.kind       = STIM_REQUEST;
      word.opcode     = opcode;
      word.hash_value = hash_value;
      word.key        = key;
      pending_q.insert(pending_q.size(), word);
   endtask

   task automatic push_drain();
      stim_word_type word;
      word      = '0;
      word.kind = STIM_DRAIN;
      pending_q.insert(pending_q.size(), word);
   endtask

   task automatic push_table_size(logic [SIZE_WIDTH-1:0] value);
      stim_word_type word;
      push_drain();
      word            = '0;
      word.kind       = STIM_TABLE_SIZE;
      word.table_size = value;
      pending_q.insert(pending_q.size(), word);
   endtask

   // Words mostly come from a pool of known keys so that later lookups and
   // repeated inserts hit; some pool entries share one hash to build long
   // collision chains.
   task automatic add_random_phase(logic [SIZE_WIDTH-1:0] size_value,
                                   int unsigned n_words, int unsigned pool_n);
      logic [KEY_IN_WIDTH-1:0] pool_key[$];
      logic [HASH_WIDTH-1:0]   pool_hash[$];
      logic [HASH_WIDTH-1:0]   hot_hash;
      int unsigned             sent;
      int unsigned             pick;
      int unsigned             roll;
      push_table_size(size_value);
      hot_hash = $urandom();
      for (int i = 0; i < pool_n; i++) begin
         pool_key.insert(pool_key.size(), {$urandom(), $urandom()});
         pool_hash.insert(pool_hash.size(),
                          ($urandom_range(0, 3) == 0) ? hot_hash : $urandom());
      end
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(0, pool_n - 1);
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            push_request(OP_INSERT, pool_hash[pick], pool_key[pick]);
         end else if (roll < 75) begin
            push_request(OP_LOOKUP, pool_hash[pick], pool_key[pick]);
         end else if (roll < 85) begin
            push_request(OP_INSERT, pool_hash[pick], pool_key[pick]);
            push_request(OP_LOOKUP, pool_hash[pick], pool_key[pick]);
            sent++;
         end else if (roll < 93) begin
            push_request(1'($urandom()), $urandom(), {$urandom(), $urandom()});
         end else begin
            push_request(1'($urandom()), $urandom(), pool_key[pick]);
         end
         sent++;
         if (sent % 100 == 0)
            push_drain();
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_LOOKUP;
      req_bus.hash_value = '0;
      req_bus.key        = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.table_size = '0;

      push_request(OP_LOOKUP, 32'h0000_0000, 64'h0);
      push_request(OP_INSERT, 32'h0000_0000, 64'h0);
      push_request(OP_INSERT, 32'h0000_0000, 64'h0);
      push_request(OP_LOOKUP, 32'h0000_0000, 64'h0);
      push_request(OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      push_request(OP_INSERT, 32'h0000_0000, 64'h1);
      push_request(OP_INSERT, 32'h0000_0000, 64'h2);
      push_request(OP_LOOKUP, 32'h0000_0000, 64'h3);
      push_request(OP_LOOKUP, 32'h0000_0FFF, 64'hFFFF_FFFF_FFFF_FFFF);
      push_table_size(SIZE_WIDTH'(1));
      push_request(OP_LOOKUP, 32'h1234_5678, 64'h0);
      push_request(OP_INSERT, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      push_request(OP_LOOKUP, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
      push_table_size(SIZE_WIDTH'(0));
      push_request(OP_LOOKUP, 32'hDEAD_BEEF, 64'h0);
      push_request(OP_INSERT, 32'h0000_0001, 64'h7);
      push_table_size(SIZE_WIDTH'(8191));
      push_request(OP_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      push_request(OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000);

      add_random_phase(SIZE_WIDTH'(4096), 300, 64);
      add_random_phase(SIZE_WIDTH'($urandom_range(2, 4095)), 250, 64);
      add_random_phase(SIZE_WIDTH'($urandom_range(3, 40)), 120, 24);
      add_random_phase(SIZE_WIDTH'(2), 20, 3);
      add_random_phase(SIZE_WIDTH'(1), 15, 2);
      add_random_phase(SIZE_WIDTH'(8191), 200, 64);
      add_random_phase(SIZE_WIDTH'(0), 15, 2);
      add_random_phase(SIZE_WIDTH'(4096), 200, 64);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_q.size() != 0 || req_bus.valid || csr_bus.valid ||
             expected_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_q.size() != 0) begin
         $display("%0d results never arrived.", expected_q.size());
         fail_count += expected_q.size();
      end

      $display("Checked %0d words: %0d hits, %0d inserts, %0d probe-limit failures.",
               n_requests, n_found, n_inserted, n_full);
      $display("Table size was written %0d times; the sender paused %0d times.",
               n_size_writes, n_pauses);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures.", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fpht_pkg.sv
hw/rtl/fpht_req_if.sv
hw/rtl/fpht_rsp_if.sv
hw/rtl/fpht_csr_if.sv
hw/rtl/fpht_ram.sv
hw/rtl/fpht_mod_unit.sv
hw/rtl/factorial_probe_hash_table.sv
sim/tb_factorial_probe_hash_table.sv
